/* hdl/mspk_pkg.sv */
// ----------------------------------------------------------------------------
// mspk_pkg
// Shared types and constants for the multi-turn sector position keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package mspk_pkg;

  // Field widths
  localparam int unsigned COMP_W   = 16;   // period compensation, signed
  localparam int unsigned POS_W    = 32;   // raw encoder position, signed
  localparam int unsigned SEC_W    = 32;   // sector number, signed
  localparam int unsigned OUT_W    = 48;   // corrected position, signed
  localparam int unsigned PER_W    = 31;   // period / sector width / margin
  localparam int unsigned SPP_W    = 11;   // sectors per period
  localparam int unsigned PROD_W   = 64;   // shared multiplier product
  localparam int unsigned ACC_W    = 66;   // wide accumulator
  localparam int unsigned CNT_W    = 5;    // divider step counter
  localparam int unsigned Q_W      = 32;   // divider quotient
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned APB_W    = 32;

  // Register reset values
  localparam logic [PER_W-1:0] PERIOD_RST = 31'd65536;
  localparam logic [PER_W-1:0] SWIDTH_RST = 31'd4096;
  localparam logic [SPP_W-1:0] SPP_RST    = 11'd16;
  localparam logic [PER_W-1:0] HYST_RST   = 31'd1024;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_SWIDTH = 2'd1;
  localparam logic [1:0] REG_SPP    = 2'd2;
  localparam logic [1:0] REG_HYST   = 2'd3;

  // Request kinds (tuser)
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REINIT = 1'b1;

  // Divider start steps: full quotient for samples, 17 bits for reinit
  localparam logic [CNT_W-1:0] DIV_SAMPLE_TOP = 5'd31;
  localparam logic [CNT_W-1:0] DIV_REINIT_TOP = 5'd16;

  // Compensation limits as magnitudes
  localparam logic [COMP_W:0]   COMP_NEG_LIM = 17'd32768;
  localparam logic [COMP_W:0]   COMP_POS_LIM = 17'd32767;
  localparam logic [COMP_W-1:0] COMP_MIN_VAL = 16'h8000;
  localparam logic [COMP_W-1:0] COMP_MAX_VAL = 16'h7FFF;

  // Corrected position limits
  localparam logic signed [ACC_W-1:0] OUT_MAX = 66'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -66'sh0_0000_8000_0000_0000;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMUL,
    ST_RDIFF,
    ST_RSEL,
    ST_SMUL_CP,
    ST_SMUL_SS,
    ST_SMUL_CS,
    ST_SOFF,
    ST_DIV,
    ST_RFIN,
    ST_SBAND,
    ST_SFIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/multiturn_sector_position_keeper.sv */
// Sequencing: a sample runs three multiply states, sector offset, divider, band check
// and sector update; a reinit runs multiply, offset and select, then the divider unless
// the start already lies within half a period (no search). The block has one shared
// restoring divider (one quotient bit per cycle, 32 steps for a sample, 17 for a reinit)
// and a shared 32x32 multiplier. One request at a time, the next taken in the cycle
// after the result loads. Reset clears sector, compensation, init flag, loads defaults.
// ----------------------------------------------------------------------------
// multiturn_sector_position_keeper
// Multi-turn position keeper: period compensation search on reinit,
// corrected position and sector tracking with hysteresis on samples.
// ----------------------------------------------------------------------------
`default_nettype none

module multiturn_sector_position_keeper (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Request stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // raw_position[31:0], restored_sector[63:32]
  input  wire logic [mspk_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                              s_axis_tuser_i,  // req_type[0]
  // Result stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // out_position[47:0], out_sector[79:48], store_request[80],
  // is_initialised[81], compensation[97:82], saturated[98], zero pad [103:99]
  output logic [mspk_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // Configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mspk_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [mspk_pkg::APB_W-1:0]        pwdata,
  output logic [mspk_pkg::APB_W-1:0]             prdata,
  output logic                                   pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mspk_pkg::PER_W-1:0] period_q, swidth_q, hyst_q;
  logic [mspk_pkg::SPP_W-1:0] spp_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= mspk_pkg::PERIOD_RST;
      swidth_q <= mspk_pkg::SWIDTH_RST;
      spp_q    <= mspk_pkg::SPP_RST;
      hyst_q   <= mspk_pkg::HYST_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mspk_pkg::REG_PERIOD: period_q <= pwdata[mspk_pkg::PER_W-1:0];
        mspk_pkg::REG_SWIDTH: swidth_q <= pwdata[mspk_pkg::PER_W-1:0];
        mspk_pkg::REG_SPP:    spp_q    <= pwdata[mspk_pkg::SPP_W-1:0];
        mspk_pkg::REG_HYST:   hyst_q   <= pwdata[mspk_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      mspk_pkg::REG_PERIOD: prdata = {1'b0, period_q};
      mspk_pkg::REG_SWIDTH: prdata = {1'b0, swidth_q};
      mspk_pkg::REG_SPP:    prdata = {21'd0, spp_q};
      mspk_pkg::REG_HYST:   prdata = {1'b0, hyst_q};
      default:              prdata = '0;
    endcase
  end

  // Zero period or width counts as one
  logic [mspk_pkg::PER_W-1:0] per_eff, sw_eff;
  assign per_eff = (period_q == '0) ? 31'd1 : period_q;
  assign sw_eff  = (swidth_q == '0) ? 31'd1 : swidth_q;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  mspk_pkg::state_e state_q, state_d;

  logic                                s_acc;
  logic                                out_free;
  logic signed [mspk_pkg::SEC_W-1:0]   ss_q;       // stored sector
  logic signed [mspk_pkg::COMP_W-1:0]  comp_q;     // period compensation
  logic                                init_q;
  logic                                mode_q;     // request kind in flight
  logic                                down_q;     // reinit search counts down
  logic                                store_q, sat_q;
  logic signed [mspk_pkg::POS_W-1:0]   raw_q;
  logic signed [mspk_pkg::PROD_W-1:0]  prod_q;
  logic signed [mspk_pkg::ACC_W-1:0]   acc_q;      // offset d, or corrected position
  logic signed [mspk_pkg::PROD_W-1:0]  hi_q, lo_q;
  logic signed [mspk_pkg::SEC_W-1:0]   secoff_q;
  logic signed [mspk_pkg::SEC_W:0]     sec_q;
  logic                                oob_q;
  logic [mspk_pkg::PROD_W-1:0]         rem_q;
  logic [mspk_pkg::Q_W-1:0]            quo_q;
  logic [mspk_pkg::CNT_W-1:0]          cnt_q;
  logic                                m_valid_q;
  logic [mspk_pkg::OUT_DATA_W-1:0]     m_data_q;

  assign s_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_valid_q | m_axis_tready_i;

  // --------------------------------------------------------------------------
  // Shared multiplier, operands picked by the sequencer
  // --------------------------------------------------------------------------
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] comp_ext;

  assign comp_ext = {{(32-mspk_pkg::COMP_W){comp_q[mspk_pkg::COMP_W-1]}}, comp_q};

  always_comb begin
    case (state_q)
      mspk_pkg::ST_SMUL_CP: begin
        mul_a = comp_ext;
        mul_b = {1'b0, per_eff};
      end
      mspk_pkg::ST_SMUL_CS: begin
        mul_a = comp_ext;
        mul_b = {21'd0, spp_q};
      end
      default: begin
        mul_a = ss_q;
        mul_b = {1'b0, sw_eff};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Shared restoring divider step: one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [31:0]                 div_m;
  logic [mspk_pkg::PROD_W:0]   div_shift, div_trial;

  assign div_m     = (mode_q == mspk_pkg::REQ_REINIT) ? {per_eff, 1'b0} : {1'b0, sw_eff};
  assign div_shift = 65'(div_m) << cnt_q;
  assign div_trial = {1'b0, rem_q} - div_shift;

  // --------------------------------------------------------------------------
  // Step helpers
  // --------------------------------------------------------------------------
  logic signed [mspk_pkg::ACC_W-1:0] raw_ext, prod_ext, per_ext, sw_ext;
  logic signed [mspk_pkg::ACC_W-1:0] d_calc, corr_calc;
  logic signed [mspk_pkg::ACC_W-1:0] hi_ext, lo_ext;
  logic signed [mspk_pkg::SEC_W-1:0] fl_q;
  logic signed [mspk_pkg::SEC_W+1:0] sec_diff;
  logic [mspk_pkg::COMP_W:0]         k_val;
  logic                              k_sat;
  logic                              move;
  logic [mspk_pkg::OUT_W-1:0]        corr_out;

  assign raw_ext   = {{(mspk_pkg::ACC_W-mspk_pkg::POS_W){raw_q[mspk_pkg::POS_W-1]}}, raw_q};
  assign prod_ext  = {{(mspk_pkg::ACC_W-mspk_pkg::PROD_W){prod_q[mspk_pkg::PROD_W-1]}}, prod_q};
  assign per_ext   = {{(mspk_pkg::ACC_W-mspk_pkg::PER_W){1'b0}}, per_eff};
  assign sw_ext    = {{(mspk_pkg::ACC_W-mspk_pkg::PER_W){1'b0}}, sw_eff};
  // twice the start's offset from the restored sector's center
  assign d_calc    = (raw_ext <<< 1) - sw_ext - (prod_ext <<< 1);
  assign corr_calc = raw_ext + prod_ext;
  assign hi_ext    = {{(mspk_pkg::ACC_W-mspk_pkg::PROD_W){hi_q[mspk_pkg::PROD_W-1]}}, hi_q};
  assign lo_ext    = {{(mspk_pkg::ACC_W-mspk_pkg::PROD_W){lo_q[mspk_pkg::PROD_W-1]}}, lo_q};

  // floor division of a negative dividend via the complement trick
  assign fl_q = raw_q[mspk_pkg::POS_W-1] ? $signed(~quo_q) : $signed(quo_q);

  // compensation magnitude from the quotient
  assign k_val = {1'b0, quo_q[mspk_pkg::COMP_W-1:0]} + 17'd1;
  assign k_sat = (quo_q[mspk_pkg::Q_W-1:mspk_pkg::COMP_W] != '0) ||
                 (down_q ? (k_val > mspk_pkg::COMP_NEG_LIM) : (k_val > mspk_pkg::COMP_POS_LIM));

  // adjacent sector, inside the 32 bit range
  assign sec_diff = {sec_q[mspk_pkg::SEC_W], sec_q} -
                    {{2{ss_q[mspk_pkg::SEC_W-1]}}, ss_q};
  assign move = oob_q && (raw_q != '0) && init_q &&
                ((sec_diff == 34'sd1) || (sec_diff == -34'sd1)) &&
                (sec_q[mspk_pkg::SEC_W] == sec_q[mspk_pkg::SEC_W-1]);

  // output clamp for the corrected position
  always_comb begin
    if (mode_q == mspk_pkg::REQ_REINIT) begin
      corr_out = '0;
    end else if (acc_q > mspk_pkg::OUT_MAX) begin
      corr_out = mspk_pkg::OUT_MAX[mspk_pkg::OUT_W-1:0];
    end else if (acc_q < mspk_pkg::OUT_MIN) begin
      corr_out = mspk_pkg::OUT_MIN[mspk_pkg::OUT_W-1:0];
    end else begin
      corr_out = acc_q[mspk_pkg::OUT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      mspk_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_d = (s_axis_tuser_i == mspk_pkg::REQ_REINIT) ? mspk_pkg::ST_RMUL
                                                             : mspk_pkg::ST_SMUL_CP;
        end
      end
      mspk_pkg::ST_RMUL:    state_d = mspk_pkg::ST_RDIFF;
      mspk_pkg::ST_RDIFF:   state_d = mspk_pkg::ST_RSEL;
      mspk_pkg::ST_RSEL: begin
        if ((acc_q > per_ext) || (acc_q < -per_ext)) begin
          state_d = mspk_pkg::ST_DIV;
        end else begin
          state_d = mspk_pkg::ST_DONE;
        end
      end
      mspk_pkg::ST_SMUL_CP: state_d = mspk_pkg::ST_SMUL_SS;
      mspk_pkg::ST_SMUL_SS: state_d = mspk_pkg::ST_SMUL_CS;
      mspk_pkg::ST_SMUL_CS: state_d = mspk_pkg::ST_SOFF;
      mspk_pkg::ST_SOFF:    state_d = mspk_pkg::ST_DIV;
      mspk_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = (mode_q == mspk_pkg::REQ_REINIT) ? mspk_pkg::ST_RFIN
                                                     : mspk_pkg::ST_SBAND;
        end
      end
      mspk_pkg::ST_RFIN:    state_d = mspk_pkg::ST_DONE;
      mspk_pkg::ST_SBAND:   state_d = mspk_pkg::ST_SFIN;
      mspk_pkg::ST_SFIN:    state_d = mspk_pkg::ST_DONE;
      mspk_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mspk_pkg::ST_IDLE;
        end
      end
      default:              state_d = mspk_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = (state_q == mspk_pkg::ST_IDLE);
    m_axis_tvalid_o = m_valid_q;
    m_axis_tdata_o  = m_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mspk_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Block state: sector, compensation, initialised flag
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q   <= '0;
      comp_q <= '0;
      init_q <= 1'b0;
    end else begin
      case (state_q)
        mspk_pkg::ST_IDLE: begin
          if (s_acc && (s_axis_tuser_i == mspk_pkg::REQ_REINIT)) begin
            ss_q   <= s_axis_tdata_i[63:32];
            comp_q <= '0;
          end
        end
        mspk_pkg::ST_RSEL: begin
          if (!((acc_q > per_ext) || (acc_q < -per_ext))) begin
            init_q <= 1'b1;
          end
        end
        mspk_pkg::ST_RFIN: begin
          init_q <= 1'b1;
          if (k_sat) begin
            comp_q <= down_q ? mspk_pkg::COMP_MIN_VAL : mspk_pkg::COMP_MAX_VAL;
          end else begin
            comp_q <= down_q ? (~k_val[mspk_pkg::COMP_W-1:0] + 16'd1)
                             : k_val[mspk_pkg::COMP_W-1:0];
          end
        end
        mspk_pkg::ST_SFIN: begin
          if (move) begin
            ss_q <= sec_q[mspk_pkg::SEC_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      mspk_pkg::ST_IDLE: begin
        if (s_acc) begin
          raw_q   <= s_axis_tdata_i[31:0];
          mode_q  <= s_axis_tuser_i;
          store_q <= 1'b0;
          sat_q   <= 1'b0;
          quo_q   <= '0;
          // |raw| - style dividend for the floor division of a sample
          rem_q   <= {32'd0, (s_axis_tdata_i[31] ? ~s_axis_tdata_i[31:0]
                                                  : s_axis_tdata_i[31:0])};
          cnt_q   <= mspk_pkg::DIV_SAMPLE_TOP;
        end
      end
      mspk_pkg::ST_RDIFF: begin
        acc_q <= d_calc;
      end
      mspk_pkg::ST_RSEL: begin
        quo_q <= '0;
        cnt_q <= mspk_pkg::DIV_REINIT_TOP;
        if (acc_q > per_ext) begin
          down_q <= 1'b1;
          rem_q  <= 64'(acc_q - per_ext - 66'sd1);
        end else begin
          down_q <= 1'b0;
          rem_q  <= 64'(~acc_q - per_ext);
        end
      end
      mspk_pkg::ST_SMUL_SS: begin
        acc_q <= corr_calc;
      end
      mspk_pkg::ST_SMUL_CS: begin
        hi_q <= prod_q + $signed({33'd0, sw_eff}) + $signed({33'd0, hyst_q});
        lo_q <= prod_q - $signed({33'd0, hyst_q});
      end
      mspk_pkg::ST_SOFF: begin
        secoff_q <= prod_q[mspk_pkg::SEC_W-1:0];
      end
      mspk_pkg::ST_DIV: begin
        if (!div_trial[mspk_pkg::PROD_W]) begin
          rem_q        <= div_trial[mspk_pkg::PROD_W-1:0];
          quo_q[cnt_q] <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
      mspk_pkg::ST_RFIN: begin
        sat_q <= k_sat;
      end
      mspk_pkg::ST_SBAND: begin
        oob_q <= (acc_q > hi_ext) || (acc_q < lo_ext);
        sec_q <= {fl_q[mspk_pkg::SEC_W-1], fl_q} +
                 {secoff_q[mspk_pkg::SEC_W-1], secoff_q};
      end
      mspk_pkg::ST_SFIN: begin
        store_q <= move;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == mspk_pkg::ST_DONE) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == mspk_pkg::ST_DONE) && out_free) begin
      m_data_q <= {5'd0, sat_q, comp_q, init_q, store_q, ss_q, corr_out};
    end
  end

`ifndef NO_ASSERTIONS
  // A store request is only raised once initialised
  a_store_needs_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[80]) |-> m_axis_tdata_o[81])
    else $error("store request without initialisation");

  // Saturation only comes from a reinit, which reports no position
  a_sat_on_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[98]) |->
      (m_axis_tdata_o[47:0] == 48'd0 && !m_axis_tdata_o[80]))
    else $error("saturation flag on a sample result");

  // The sequencer is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // Divider counter steps down by one in every divide cycle
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mspk_pkg::ST_DIV && cnt_q != '0) |=>
      (state_q == mspk_pkg::ST_DIV && cnt_q == $past(cnt_q) - 5'd1))
    else $error("divider sequence broken");
`endif

endmodule

`default_nettype wire

/* tb/sv/position_keeper_checker.sv */
// ----------------------------------------------------------------------------
// position_keeper_checker
// Watches the request, result and register ports of the multi-turn position
// keeper, predicts each result from its own copy of the keeper state and
// compares it field by field against what the block delivers.
// ----------------------------------------------------------------------------
module position_keeper_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request channel
  input  logic         req_valid_i,
  input  logic         req_ready_i,
  input  logic [63:0]  req_data_i,    // raw_position[31:0], restored_sector[63:32]
  input  logic         req_kind_i,    // req_type[0]
  // result channel
  input  logic         res_valid_i,
  input  logic         res_ready_i,
  // out_position[47:0], out_sector[79:48], store_request[80],
  // is_initialised[81], compensation[97:82], saturated[98]
  input  logic [103:0] res_data_i,
  // register port
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [3:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  input  logic         pready_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Limits in the wide working format
  localparam logic signed [95:0] SEC_HI   = 96'sd2147483647;
  localparam logic signed [95:0] SEC_LO   = -96'sd2147483648;
  localparam logic signed [95:0] POS_HI   = 96'sd140737488355327;
  localparam logic signed [95:0] POS_LO   = -96'sd140737488355328;
  localparam logic signed [95:0] COMP_NEG = 96'sd32768;
  localparam logic signed [95:0] COMP_POS = 96'sd32767;

  typedef struct {
    logic signed [47:0] position;
    logic signed [31:0] sector;
    logic               store_req;
    logic               init_flag;
    logic signed [15:0] comp;
    logic               sat;
  } keeper_out_t;

  // Register copies
  logic [mspk_pkg::PER_W-1:0] period_cfg;
  logic [mspk_pkg::PER_W-1:0] width_cfg;
  logic [mspk_pkg::SPP_W-1:0] spp_cfg;
  logic [mspk_pkg::PER_W-1:0] hyst_cfg;

  // Keeper state
  logic signed [mspk_pkg::SEC_W-1:0]  sector_q;
  logic signed [mspk_pkg::COMP_W-1:0] comp_q;
  logic                               init_q;

  keeper_out_t pending_outputs[$];
  int          mismatches;

  // Advance the keeper state by one request and return the result it gives.
  // All arithmetic runs at 96 bits so that no intermediate wraps.
  function automatic keeper_out_t predict_keeper_output(input logic kind,
      input logic signed [31:0] raw, input logic signed [31:0] restored);
    keeper_out_t       o;
    logic signed [95:0] per, sw, spx, hy, rx, cx, sx, d, k, corr, sec, q, hi, lo;
    per = {65'd0, period_cfg};
    if (per == 0) per = 1;
    sw = {65'd0, width_cfg};
    if (sw == 0) sw = 1;
    spx = {85'd0, spp_cfg};
    hy = {65'd0, hyst_cfg};
    rx = raw;
    corr = 0;
    o.store_req = 1'b0;
    o.sat = 1'b0;
    if (kind == mspk_pkg::REQ_REINIT) begin
      sector_q = restored;
      comp_q = '0;
      sx = restored;
      // twice the start's offset from the restored sector's center
      d = 2 * rx - sw - 2 * (sx * sw);
      if (d > per) begin
        k = (d + per - 1) / (2 * per);
        if (k > COMP_NEG) begin
          comp_q = mspk_pkg::COMP_MIN_VAL;
          o.sat = 1'b1;
        end else begin
          comp_q = 16'(-k);
        end
      end else if (d < -per) begin
        k = (per - d - 1) / (2 * per);
        if (k > COMP_POS) begin
          comp_q = mspk_pkg::COMP_MAX_VAL;
          o.sat = 1'b1;
        end else begin
          comp_q = 16'(k);
        end
      end
      init_q = 1'b1;
    end else begin
      cx = comp_q;
      corr = rx + cx * per;
      // floor division of the raw sample by the sector width
      q = rx / sw;
      if ((rx % sw) != 0 && rx < 0) q = q - 1;
      sec = q + cx * spx;
      sx = sector_q;
      hi = (sx + 1) * sw + hy;
      lo = sx * sw - hy;
      if ((corr > hi || corr < lo) && rx != 0 && init_q &&
          (sec - sx == 1 || sx - sec == 1) && sec >= SEC_LO && sec <= SEC_HI) begin
        sector_q = 32'(sec);
        o.store_req = 1'b1;
      end
      if (corr > POS_HI) corr = POS_HI;
      if (corr < POS_LO) corr = POS_LO;
    end
    o.position = 48'(corr);
    o.sector = sector_q;
    o.init_flag = init_q;
    o.comp = comp_q;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Track registers, queue predictions on requests, compare on results
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    keeper_out_t want;
    keeper_out_t got;
    if (!rst_ni) begin
      period_cfg = mspk_pkg::PERIOD_RST;
      width_cfg = mspk_pkg::SWIDTH_RST;
      spp_cfg = mspk_pkg::SPP_RST;
      hyst_cfg = mspk_pkg::HYST_RST;
      sector_q = '0;
      comp_q = '0;
      init_q = 1'b0;
      pending_outputs.delete();
      mismatches = 0;
    end else begin
      // result first: a request taken on this edge cannot be answered yet
      if (res_valid_i && res_ready_i) begin
        got.position = res_data_i[47:0];
        got.sector = res_data_i[79:48];
        got.store_req = res_data_i[80];
        got.init_flag = res_data_i[81];
        got.comp = res_data_i[97:82];
        got.sat = res_data_i[98];
        if (pending_outputs.size() == 0) begin
          $error("result with no request outstanding: tdata %h", res_data_i);
          mismatches++;
        end else begin
          want = pending_outputs.pop_front();
          check_field("out_position", want.position, got.position);
          check_field("out_sector", want.sector, got.sector);
          check_field("store_request", want.store_req, got.store_req);
          check_field("is_initialised", want.init_flag, got.init_flag);
          check_field("compensation", want.comp, got.comp);
          check_field("saturated", want.sat, got.sat);
        end
      end
      if (req_valid_i && req_ready_i)
        pending_outputs.push_back(predict_keeper_output(req_kind_i, req_data_i[31:0],
                                                        req_data_i[63:32]));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          mspk_pkg::REG_PERIOD: period_cfg = pwdata_i[mspk_pkg::PER_W-1:0];
          mspk_pkg::REG_SWIDTH: width_cfg = pwdata_i[mspk_pkg::PER_W-1:0];
          mspk_pkg::REG_SPP:    spp_cfg = pwdata_i[mspk_pkg::SPP_W-1:0];
          mspk_pkg::REG_HYST:   hyst_cfg = pwdata_i[mspk_pkg::PER_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o <= pending_outputs.size();
  end

endmodule

/* tb/sv/multiturn_sector_position_keeper_tb.sv */
// ----------------------------------------------------------------------------
// multiturn_sector_position_keeper_tb
// Drives reinit and sample requests through the position keeper under several
// register settings, with random gaps on both streams and one long result
// stall; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module multiturn_sector_position_keeper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     IDLE_LIMIT     = 4000;
  localparam int     SQUEEZE_CYCLES = 400;
  localparam int     SETTLE_CYCLES  = 60;
  localparam int     PHASE_ITEMS    = 90;
  localparam int     PHASE_COUNT    = 7;
  localparam longint I32_MAX        = 64'sd2147483647;
  localparam longint I32_MIN        = -64'sd2147483648;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;    // raw_position[31:0], restored_sector[63:32]
  logic         s_tuser = 1'b0;  // req_type[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // out_position[47:0], out_sector[79:48], store_request[80],
  // is_initialised[81], compensation[97:82], saturated[98]
  logic [103:0] m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int     fails;
  int     pending;
  int     results_seen = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;
  longint walk_raw = 0;
  longint eff_per = 65536;
  longint eff_sw = 4096;
  longint eff_hyst = 1024;

  multiturn_sector_position_keeper u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  position_keeper_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_data_i   (s_tdata),
    .req_kind_i   (s_tuser),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result counter, used to place the long stall mid-run
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) results_seen <= results_seen + 1;
  end

  // Watchdog: ends the run after too long without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Uniform value in [-lim, lim]
  function automatic longint span(input longint lim);
    longint unsigned r;
    longint unsigned m;
    r = {$urandom, $urandom};
    m = 2 * lim + 1;
    return longint'(r % m) - lim;
  endfunction

  function automatic logic [31:0] to_i32(input longint v);
    if (v > I32_MAX) v = I32_MAX;
    if (v < I32_MIN) v = I32_MIN;
    return v[31:0];
  endfunction

  task automatic send_request(input logic kind, input logic [31:0] raw,
                              input logic [31:0] restored);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {restored, raw};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Stop offering, wait out every outstanding result plus the block latency
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] per, input logic [31:0] sw,
                               input logic [31:0] spp, input logic [31:0] hyst);
    drain();
    write_reg(mspk_pkg::REG_PERIOD, per);
    write_reg(mspk_pkg::REG_SWIDTH, sw);
    write_reg(mspk_pkg::REG_SPP, spp);
    write_reg(mspk_pkg::REG_HYST, hyst);
    eff_per = longint'(per[mspk_pkg::PER_W-1:0]);
    if (eff_per == 0) eff_per = 1;
    eff_sw = longint'(sw[mspk_pkg::PER_W-1:0]);
    if (eff_sw == 0) eff_sw = 1;
    eff_hyst = longint'(hyst[mspk_pkg::PER_W-1:0]);
  endtask

  // Mostly a random walk of the encoder with occasional reinits, most of them near the
  // walk's sector, plus noise samples and zero samples
  task automatic send_random_item();
    int     roll;
    int     off;
    int     turns;
    longint sec;
    longint raw;
    roll = $urandom_range(0, 99);
    if (roll < 7) begin
      if ($urandom_range(0, 3) == 0) begin
        sec = longint'($signed($urandom));
        raw = longint'($signed($urandom));
      end else begin
        off = $urandom_range(0, 4);
        turns = $urandom_range(0, 4);
        sec = walk_raw / eff_sw + off - 2;
        if (sec > I32_MAX) sec = I32_MAX;
        if (sec < I32_MIN) sec = I32_MIN;
        raw = sec * eff_sw + eff_sw / 2 + span(eff_sw) - (turns - 2) * eff_per;
      end
      walk_raw = $signed(to_i32(raw));
      send_request(mspk_pkg::REQ_REINIT, to_i32(raw), to_i32(sec));
    end else begin
      if (roll < 13) raw = longint'($signed($urandom));
      else if (roll < 16) raw = 0;
      else raw = walk_raw + span(eff_sw + eff_hyst);
      walk_raw = $signed(to_i32(raw));
      send_request(mspk_pkg::REQ_SAMPLE, to_i32(raw), $urandom);
    end
  endtask

  // Result side: random stalls, long ready stretches, one long hold-off
  initial begin : result_sink
    int r;
    int len;
    bit squeezed;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!squeezed && results_seen >= 150) begin
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          m_tready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 60) begin
          m_tready <= 1'b1;
          len = $urandom_range(40, 200);
        end else if (r < 95) begin
          m_tready <= 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          m_tready <= 1'b0;
          len = $urandom_range(10, 80);
        end
        repeat (len - 1) @(posedge clk_i);
      end
    end
  end

  // Request side
  initial begin : stimulus
    int ph;
    int n;
    int spp_pick;
    int sw_pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: samples before any reinit, then search edge cases
    send_request(mspk_pkg::REQ_SAMPLE, 32'd9000, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h8000_0000, 32'h8000_0000);
    // offset of exactly plus and minus half a period, and one count past
    send_request(mspk_pkg::REQ_REINIT, 32'd34816, 32'd0);
    send_request(mspk_pkg::REQ_REINIT, 32'd34817, 32'd0);
    send_request(mspk_pkg::REQ_REINIT, -32'sd30720, 32'd0);
    send_request(mspk_pkg::REQ_REINIT, -32'sd30721, 32'd0);
    // compensation at its negative limit, then one period past it
    send_request(mspk_pkg::REQ_REINIT, 32'd34816, -32'sd524288);
    send_request(mspk_pkg::REQ_REINIT, 32'd34817, -32'sd524288);
    // compensation at its positive limit, then one period past it
    send_request(mspk_pkg::REQ_REINIT, 32'd34816, 32'd524288);
    send_request(mspk_pkg::REQ_REINIT, 32'd34815, 32'd524288);
    send_request(mspk_pkg::REQ_REINIT, 32'd0, 32'h7FFF_FFFF);
    send_request(mspk_pkg::REQ_REINIT, 32'h8000_0000, 32'h8000_0000);
    // sector tracking with hysteresis around sector 2
    send_request(mspk_pkg::REQ_REINIT, 32'd10000, 32'd2);
    send_request(mspk_pkg::REQ_SAMPLE, 32'd13313, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'd13000, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'd11263, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'd0, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'd30000, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, -32'sd1, 32'd0);
    send_request(mspk_pkg::REQ_REINIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h7FFF_FFFF, 32'd0);

    // Unit sectors: moves that would leave the 32 bit sector range
    apply_setting(32'd2048, 32'd1, 32'd1024, 32'd0);
    send_request(mspk_pkg::REQ_REINIT, 32'h7FFF_FFFF - 32'd2000, 32'h7FFF_FFFF);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h7FFF_FFFF - 32'd1023, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h7FFF_FFFF - 32'd1025, 32'd0);
    send_request(mspk_pkg::REQ_REINIT, 32'h8000_0000 + 32'd2000, 32'h8000_0000);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h8000_0000 + 32'd1023, 32'd0);
    send_request(mspk_pkg::REQ_SAMPLE, 32'h8000_0000 + 32'd1025, 32'd0);

    // Random phases over a range of settings, extremes among them
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: apply_setting(32'd65536, 32'd4096, 32'd16, 32'd1024);
        1: apply_setting(32'd2, 32'd1, 32'd1, 32'd0);
        2: apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1024, 32'h7FFF_FFFF);
        3: apply_setting(32'd0, 32'd0, 32'd0, 32'd0);
        4, 5: begin
          spp_pick = $urandom_range(1, 1024);
          sw_pick = $urandom_range(1, 3000);
          apply_setting(32'(sw_pick * spp_pick), 32'(sw_pick), 32'(spp_pick),
                        $urandom_range(0, sw_pick));
        end
        default: apply_setting($urandom, $urandom, $urandom, $urandom);
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
      calm = 1'b0;
    end

    drain();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
